// ----- hw/rtl/w2f_pkg.sv -----
// Shared types, constants and table functions for the world to frame transform.
// No dependencies; every other file of the block imports this package.
package w2f_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_YAW_ANGLE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VIEW_EXTENT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ROTATE_MODE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_SHAPE = 3'd5;

    localparam logic [30:0] EXTENT_RESET = 31'd256;

    // Frame divider: rounded offset / extent, 24 quotient bits
    localparam int FDIV_NW = 51;
    localparam int FDIV_DW = 32;
    localparam int FDIV_QB = 24;
    // Edge divider: rounded component / length, 17 quotient bits
    localparam int EDIV_NW = 49;
    localparam int EDIV_DW = 33;
    localparam int EDIV_QB = 17;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic adv;
        logic valid;
    } pipe_ctl_t;

    // Multiply a Q30 series term by x twice, before the factorial step
    function automatic longint unsigned term_step(longint unsigned term, longint unsigned x);
        return (((term * x) >> 30) * x) >> 30;
    endfunction

    // Round a Q30 series sum to Q16 and limit it to [0, 1.0]
    function automatic logic [16:0] q16_round(longint sum);
        longint s;
        s = sum;
        if (s < 0)
            s = 0;
        s = (s + 8192) >>> 14;
        if (s > 65536)
            s = 65536;
        return 17'(s);
    endfunction

endpackage

// ----- hw/rtl/w2f_sincos.sv -----
// Sine/cosine lookup for the view yaw: quarter-wave constant table plus quadrant fold.
// Depends on w2f_pkg for the table functions.
module w2f_sincos
    import w2f_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
)
(
    input  logic               clk,
    input  logic [15:0]        yaw_angle,
    input  logic               rotate_mode,
    output logic signed [17:0] sin_val,
    output logic signed [17:0] cos_val
);

    localparam int QN = 1 << (SINE_TABLE_BITS - 2);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    logic [16:0] sin_tab [QN];
    logic [16:0] cos_tab [QN];

    for (genvar g = 0; g < QN; g++) begin : g_tab
        // angle of this entry, Q30 radians
        localparam longint unsigned X  = (longint'(g) * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
        // sine series: odd powers up to the 15th
        localparam longint unsigned S1 = term_step(X, X) / 6;
        localparam longint unsigned S2 = term_step(S1, X) / 20;
        localparam longint unsigned S3 = term_step(S2, X) / 42;
        localparam longint unsigned S4 = term_step(S3, X) / 72;
        localparam longint unsigned S5 = term_step(S4, X) / 110;
        localparam longint unsigned S6 = term_step(S5, X) / 156;
        localparam longint unsigned S7 = term_step(S6, X) / 210;
        localparam longint          SS = longint'(X) - longint'(S1) + longint'(S2)
                                         - longint'(S3) + longint'(S4) - longint'(S5)
                                         + longint'(S6) - longint'(S7);
        // cosine series: even powers up to the 14th
        localparam longint unsigned C0 = 64'd1 << 30;
        localparam longint unsigned C1 = term_step(C0, X) / 2;
        localparam longint unsigned C2 = term_step(C1, X) / 12;
        localparam longint unsigned C3 = term_step(C2, X) / 30;
        localparam longint unsigned C4 = term_step(C3, X) / 56;
        localparam longint unsigned C5 = term_step(C4, X) / 90;
        localparam longint unsigned C6 = term_step(C5, X) / 132;
        localparam longint unsigned C7 = term_step(C6, X) / 182;
        localparam longint          CS = longint'(C0) - longint'(C1) + longint'(C2)
                                         - longint'(C3) + longint'(C4) - longint'(C5)
                                         + longint'(C6) - longint'(C7);
        localparam logic [16:0] SV = q16_round(SS);
        localparam logic [16:0] CV = q16_round(CS);
        assign sin_tab[g] = SV;
        assign cos_tab[g] = CV;
    end

    logic [SINE_TABLE_BITS-1:0] idx;
    logic [SINE_TABLE_BITS-3:0] r;
    logic signed [17:0]         qs;
    logic signed [17:0]         qc;
    logic signed [17:0]         sin_next;
    logic signed [17:0]         cos_next;
    logic signed [17:0]         sin_reg;
    logic signed [17:0]         cos_reg;

    assign idx = yaw_angle[15 -: SINE_TABLE_BITS];
    assign r   = idx[SINE_TABLE_BITS-3:0];
    assign qs  = $signed({1'b0, sin_tab[r]});
    assign qc  = $signed({1'b0, cos_tab[r]});

    always_comb
    begin
        case (idx[SINE_TABLE_BITS-1 -: 2])
            QUAD_0:  begin sin_next = qs;  cos_next = qc;  end
            QUAD_1:  begin sin_next = qc;  cos_next = -qs; end
            QUAD_2:  begin sin_next = -qs; cos_next = -qc; end
            QUAD_3:  begin sin_next = -qc; cos_next = qs;  end
            default: begin sin_next = qs;  cos_next = qc;  end
        endcase
        // fixed north: identity rotation gives offset << 16
        if (!rotate_mode)
        begin
            sin_next = '0;
            cos_next = 18'sd65536;
        end
    end

    always_ff @(posedge clk)
    begin
        sin_reg <= sin_next;
        cos_reg <= cos_next;
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

// ----- hw/rtl/w2f_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// Depends on w2f_pkg for the pipeline control struct.
module w2f_div
    import w2f_pkg::*;
#(
    parameter int NW = FDIV_NW,
    parameter int DW = FDIV_DW,
    parameter int QB = FDIV_QB,
    parameter int TW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  pipe_ctl_t     ctl,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [TW-1:0] tag,
    output logic          out_valid,
    output logic [QB-1:0] quot,
    output logic          ovf,
    output logic [TW-1:0] out_tag
);

    localparam int WW = (NW > DW + QB) ? NW : DW + QB;

    logic          valid_reg [QB+1];
    logic [NW-1:0] rem_reg   [QB+1];
    logic [DW-1:0] den_reg   [QB+1];
    logic [QB-1:0] quot_reg  [QB+1];
    logic          ovf_reg   [QB+1];
    logic [TW-1:0] tag_reg   [QB+1];
    logic          ovf_next;

    // quotient would not fit: caller saturates
    assign ovf_next = WW'(num) >= (WW'(den) << QB);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (ctl.adv)
            valid_reg[0] <= ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            rem_reg[0]  <= num;
            den_reg[0]  <= den;
            quot_reg[0] <= '0;
            ovf_reg[0]  <= ovf_next;
            tag_reg[0]  <= tag;
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_step
        localparam int K = QB - j;
        logic [WW-1:0] shifted;
        logic          take;
        logic [NW-1:0] rem_next;
        logic [QB-1:0] quot_next;

        assign shifted   = WW'(den_reg[j-1]) << K;
        assign take      = WW'(rem_reg[j-1]) >= shifted;
        assign rem_next  = take ? NW'(WW'(rem_reg[j-1]) - shifted) : rem_reg[j-1];
        assign quot_next = quot_reg[j-1] | (take ? (QB'(1) << K) : '0);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j] <= 1'b0;
            else if (ctl.adv)
                valid_reg[j] <= valid_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (ctl.adv)
            begin
                rem_reg[j]  <= rem_next;
                den_reg[j]  <= den_reg[j-1];
                quot_reg[j] <= quot_next;
                ovf_reg[j]  <= ovf_reg[j-1];
                tag_reg[j]  <= tag_reg[j-1];
            end
        end
    end

    assign out_valid = valid_reg[QB];
    assign quot      = quot_reg[QB];
    assign ovf       = ovf_reg[QB];
    assign out_tag   = tag_reg[QB];

endmodule

// ----- hw/rtl/w2f_isqrt.sv -----
// Pipelined integer square root of a 64-bit value, one result bit per stage.
// Depends on w2f_pkg for the pipeline control struct.
module w2f_isqrt
    import w2f_pkg::*;
#(
    parameter int TW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  pipe_ctl_t     ctl,
    input  logic [63:0]   val,
    input  logic [TW-1:0] tag,
    output logic          out_valid,
    output logic [31:0]   root,
    output logic [TW-1:0] out_tag
);

    localparam int NS = 32;

    logic          valid_reg [NS+1];
    logic [63:0]   v_reg     [NS+1];
    logic [63:0]   res_reg   [NS+1];
    logic [TW-1:0] tag_reg   [NS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (ctl.adv)
            valid_reg[0] <= ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            v_reg[0]   <= val;
            res_reg[0] <= '0;
            tag_reg[0] <= tag;
        end
    end

    for (genvar i = 1; i <= NS; i++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (64 - 2 * i);
        logic [64:0] trial;
        logic        take;
        logic [63:0] v_next;
        logic [63:0] res_next;

        assign trial    = {1'b0, res_reg[i-1]} + {1'b0, BIT};
        assign take     = {1'b0, v_reg[i-1]} >= trial;
        assign v_next   = take ? 64'({1'b0, v_reg[i-1]} - trial) : v_reg[i-1];
        assign res_next = take ? (res_reg[i-1] >> 1) + BIT : res_reg[i-1] >> 1;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (ctl.adv)
                valid_reg[i] <= valid_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (ctl.adv)
            begin
                v_reg[i]   <= v_next;
                res_reg[i] <= res_next;
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[NS];
    assign root      = res_reg[NS][31:0];
    assign out_tag   = tag_reg[NS];

endmodule

// ----- hw/rtl/world_to_frame_transform_core.sv -----
// Top level of the world to frame transform: config registers, offset/rotate stages,
// frame dividers, edge length and clamp. Uses w2f_pkg, w2f_sincos, w2f_div, w2f_isqrt.
//
// Usage:
//   Input stream s_axis carries one world point per transfer; output stream m_axis
//   returns one frame point per input, in order. Configuration goes through
//   cfg_wr_en/cfg_index/cfg_data, one register per cycle, while no point is in flight.
// Pipeline: 3 offset/rotate stages, 25 in the frame divider, 3 magnitude/square
//   stages, 33 in the square root, 18 in the edge divider, 1 output register.
// Throughput: one point per cycle while the output is not stalled. The long dependent
//   chains (the two divisions and the square root) are unrolled one bit per stage, so
//   every stage takes a new point each cycle unless the pipeline holds.
// Stall: when m_axis_tready is low and a result sits in the output register, the
//   whole pipeline holds, except that a bubble in front of the output register is
//   squeezed out, so input transfers continue until the stage ahead of it is full.
// Reset: all valid bits clear, registers return to origin 0, yaw 0, extent 256,
//   fixed north, rectangle frame.
module world_to_frame_transform_core
    import w2f_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [63:0]            s_axis_tdata,   // world_x[31:0], world_y[63:32]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [87:0]            m_axis_tdata,   // frame_x[23:0], frame_y[47:24],
                                                   // clamped_x[65:48], clamped_y[83:66]
    output logic                   m_axis_tuser,   // inside_res
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef struct packed {
        logic signed [23:0] fx;
        logic signed [23:0] fy;
        logic [23:0]        m;
        logic               in_frame;
    } edge_tag_t;

    // ---------------- configuration registers ----------------
    logic signed [31:0] origin_x_reg;
    logic signed [31:0] origin_y_reg;
    logic [15:0]        yaw_angle_reg;
    logic [30:0]        view_extent_reg;
    logic               rotate_mode_reg;
    logic               frame_shape_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            yaw_angle_reg   <= '0;
            view_extent_reg <= EXTENT_RESET;
            rotate_mode_reg <= 1'b0;
            frame_shape_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ORIGIN_X:    origin_x_reg    <= cfg_data;
                REG_ORIGIN_Y:    origin_y_reg    <= cfg_data;
                REG_YAW_ANGLE:   yaw_angle_reg   <= cfg_data[15:0];
                REG_VIEW_EXTENT: view_extent_reg <= cfg_data[30:0];
                REG_ROTATE_MODE: rotate_mode_reg <= cfg_data[0];
                REG_FRAME_SHAPE: frame_shape_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // ---------------- pipeline advance ----------------
    logic      adv;
    logic      pre_valid;
    logic      m_valid_reg;
    logic      out_load;

    // advance while the output slot frees up, or while nothing reaches it
    assign adv           = !m_valid_reg || m_axis_tready || !pre_valid;
    assign out_load      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // ---------------- sine / cosine ----------------
    logic signed [17:0] sin_val;
    logic signed [17:0] cos_val;

    w2f_sincos #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sincos (
        .clk         (clk),
        .yaw_angle   (yaw_angle_reg),
        .rotate_mode (rotate_mode_reg),
        .sin_val     (sin_val),
        .cos_val     (cos_val)
    );

    // ---------------- S1: offsets ----------------
    logic               v1_reg;
    logic signed [32:0] dx_reg;
    logic signed [32:0] dy_reg;

    // ---------------- S2: products ----------------
    logic               v2_reg;
    logic signed [50:0] pxc_reg;
    logic signed [50:0] pys_reg;
    logic signed [50:0] pyc_reg;
    logic signed [50:0] pxs_reg;

    // ---------------- S3: rotated offset ----------------
    logic               v3_reg;
    logic signed [51:0] ax_reg;
    logic signed [51:0] ay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg  <= 33'($signed(s_axis_tdata[31:0])) - 33'(origin_x_reg);
            dy_reg  <= 33'($signed(s_axis_tdata[63:32])) - 33'(origin_y_reg);
            pxc_reg <= dx_reg * cos_val;
            pys_reg <= dy_reg * sin_val;
            pyc_reg <= dy_reg * cos_val;
            pxs_reg <= dx_reg * sin_val;
            ax_reg  <= 52'(pxc_reg) + 52'(pys_reg);
            ay_reg  <= 52'(pyc_reg) - 52'(pxs_reg);
        end
    end

    // ---------------- frame dividers ----------------
    // frame_x = round(ay / extent), frame_y = round(-ax / extent)
    logic [51:0]          ax_mag;
    logic [51:0]          ay_mag;
    logic [FDIV_NW-1:0]   fnum_x;
    logic [FDIV_NW-1:0]   fnum_y;
    logic [FDIV_DW-1:0]   fden;
    pipe_ctl_t            fctl;
    logic                 fdx_valid;
    logic                 fdy_valid;
    logic [FDIV_QB-1:0]   fq_x;
    logic [FDIV_QB-1:0]   fq_y;
    logic                 fovf_x;
    logic                 fovf_y;
    logic                 fneg_x;
    logic                 fneg_y;

    assign ax_mag   = ax_reg[51] ? 52'(-ax_reg) : 52'(ax_reg);
    assign ay_mag   = ay_reg[51] ? 52'(-ay_reg) : 52'(ay_reg);
    assign fnum_x   = FDIV_NW'({ay_mag[49:0], 1'b0}) + FDIV_NW'(view_extent_reg);
    assign fnum_y   = FDIV_NW'({ax_mag[49:0], 1'b0}) + FDIV_NW'(view_extent_reg);
    assign fden     = {view_extent_reg, 1'b0};
    assign fctl.adv   = adv;
    assign fctl.valid = v3_reg;

    w2f_div #(
        .NW (FDIV_NW),
        .DW (FDIV_DW),
        .QB (FDIV_QB),
        .TW (1)
    ) u_fdiv_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (fctl),
        .num       (fnum_x),
        .den       (fden),
        .tag       (ay_reg[51]),
        .out_valid (fdx_valid),
        .quot      (fq_x),
        .ovf       (fovf_x),
        .out_tag   (fneg_x)
    );

    w2f_div #(
        .NW (FDIV_NW),
        .DW (FDIV_DW),
        .QB (FDIV_QB),
        .TW (1)
    ) u_fdiv_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (fctl),
        .num       (fnum_y),
        .den       (fden),
        .tag       (!ax_reg[51] && (ax_reg != '0)),
        .out_valid (fdy_valid),
        .quot      (fq_y),
        .ovf       (fovf_y),
        .out_tag   (fneg_y)
    );

    // saturate a rounded magnitude to signed Q7.16
    function automatic logic signed [23:0] frame_sat(logic neg, logic [23:0] q, logic o);
        logic signed [23:0] r;
        if (neg)
            r = (o || q > 24'd8388608) ? -24'sd8388608 : $signed(24'(-q));
        else
            r = (o || q > 24'd8388607) ? 24'sd8388607 : $signed(q);
        return r;
    endfunction

    // ---------------- F: frame point ----------------
    logic               vf_reg;
    logic signed [23:0] fx_reg;
    logic signed [23:0] fy_reg;
    logic signed [23:0] fx_next;
    logic signed [23:0] fy_next;

    always_comb
    begin
        fx_next = frame_sat(fneg_x, fq_x, fovf_x);
        fy_next = frame_sat(fneg_y, fq_y, fovf_y);
        // zero extent gives the origin of the frame
        if (view_extent_reg == '0)
        begin
            fx_next = '0;
            fy_next = '0;
        end
    end

    // ---------------- G: magnitudes and squares ----------------
    logic               vg_reg;
    logic signed [23:0] gx_reg;
    logic signed [23:0] gy_reg;
    logic [23:0]        gm_reg;
    logic [47:0]        sqx_reg;
    logic [47:0]        sqy_reg;
    logic               in_rect_reg;
    logic [23:0]        mx;
    logic [23:0]        my;

    assign mx = fx_reg[23] ? 24'(-fx_reg) : 24'(fx_reg);
    assign my = fy_reg[23] ? 24'(-fy_reg) : 24'(fy_reg);

    // ---------------- H: length squared ----------------
    logic               vh_reg;
    edge_tag_t          htag_reg;
    logic [47:0]        sq_reg;
    edge_tag_t          htag_next;
    logic [47:0]        sq_next;

    assign sq_next            = sqx_reg + sqy_reg;
    assign htag_next.fx       = gx_reg;
    assign htag_next.fy       = gy_reg;
    assign htag_next.m        = gm_reg;
    assign htag_next.in_frame = frame_shape_reg ? (sq_next <= 48'h1_0000_0000) : in_rect_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
            vh_reg <= 1'b0;
        end
        else if (adv)
        begin
            vf_reg <= fdx_valid && fdy_valid;
            vg_reg <= vf_reg;
            vh_reg <= vg_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fx_reg      <= fx_next;
            fy_reg      <= fy_next;
            gx_reg      <= fx_reg;
            gy_reg      <= fy_reg;
            gm_reg      <= (mx > my) ? mx : my;
            sqx_reg     <= mx * mx;
            sqy_reg     <= my * my;
            in_rect_reg <= (mx <= 24'd65536) && (my <= 24'd65536);
            htag_reg    <= htag_next;
            sq_reg      <= sq_next;
        end
    end

    // ---------------- edge length: floor(sqrt(sq << 16)) ----------------
    pipe_ctl_t  sctl;
    logic       sq_valid;
    logic [31:0] len8;
    edge_tag_t  stag;

    assign sctl.adv   = adv;
    assign sctl.valid = vh_reg;

    w2f_isqrt #(
        .TW ($bits(edge_tag_t))
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (sctl),
        .val       ({sq_reg, 16'd0}),
        .tag       (htag_reg),
        .out_valid (sq_valid),
        .root      (len8),
        .out_tag   (stag)
    );

    // ---------------- edge dividers ----------------
    // rectangle: |c| * 2^16 / max, circle: |c| * 2^24 / len8, both rounded
    logic [EDIV_DW-2:0]  edge_d;
    logic [23:0]         emx;
    logic [23:0]         emy;
    logic [EDIV_NW-1:0]  enum_x;
    logic [EDIV_NW-1:0]  enum_y;
    logic [EDIV_DW-1:0]  eden;
    pipe_ctl_t           ectl;
    logic                edx_valid;
    logic                edy_valid;
    logic [EDIV_QB-1:0]  eq_x;
    logic [EDIV_QB-1:0]  eq_y;
    logic                eovf_x;
    logic                eovf_y;
    logic [24:0]         etag_x;
    logic [23:0]         etag_y;

    assign emx    = stag.fx[23] ? 24'(-stag.fx) : 24'(stag.fx);
    assign emy    = stag.fy[23] ? 24'(-stag.fy) : 24'(stag.fy);
    assign edge_d = frame_shape_reg ? len8 : 32'(stag.m);
    assign enum_x = frame_shape_reg ? EDIV_NW'({emx, 25'd0}) + EDIV_NW'(edge_d)
                                    : EDIV_NW'({emx, 17'd0}) + EDIV_NW'(edge_d);
    assign enum_y = frame_shape_reg ? EDIV_NW'({emy, 25'd0}) + EDIV_NW'(edge_d)
                                    : EDIV_NW'({emy, 17'd0}) + EDIV_NW'(edge_d);
    assign eden   = {edge_d, 1'b0};
    assign ectl.adv   = adv;
    assign ectl.valid = sq_valid;

    w2f_div #(
        .NW (EDIV_NW),
        .DW (EDIV_DW),
        .QB (EDIV_QB),
        .TW (25)
    ) u_ediv_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ectl),
        .num       (enum_x),
        .den       (eden),
        .tag       ({stag.in_frame, stag.fx}),
        .out_valid (edx_valid),
        .quot      (eq_x),
        .ovf       (eovf_x),
        .out_tag   (etag_x)
    );

    w2f_div #(
        .NW (EDIV_NW),
        .DW (EDIV_DW),
        .QB (EDIV_QB),
        .TW (24)
    ) u_ediv_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ectl),
        .num       (enum_y),
        .den       (eden),
        .tag       (stag.fy),
        .out_valid (edy_valid),
        .quot      (eq_y),
        .ovf       (eovf_y),
        .out_tag   (etag_y)
    );

    assign pre_valid = edx_valid && edy_valid;

    // pull onto the edge, limit to [-1, 1] in Q1.16
    function automatic logic signed [17:0] edge_sat(logic neg, logic [16:0] q, logic o);
        logic [17:0] m;
        m = (o || q > 17'd65536) ? 18'd65536 : {1'b0, q};
        return neg ? $signed(18'(-m)) : $signed(m);
    endfunction

    // ---------------- output register ----------------
    logic signed [23:0] ofx;
    logic signed [23:0] ofy;
    logic               oin;
    logic signed [17:0] ocx_next;
    logic signed [17:0] ocy_next;
    logic signed [23:0] frame_x_reg;
    logic signed [23:0] frame_y_reg;
    logic               inside_reg;
    logic signed [17:0] clamped_x_reg;
    logic signed [17:0] clamped_y_reg;

    assign ofx      = etag_x[23:0];
    assign oin      = etag_x[24];
    assign ofy      = etag_y;
    assign ocx_next = oin ? ofx[17:0] : edge_sat(ofx[23], eq_x, eovf_x);
    assign ocy_next = oin ? ofy[17:0] : edge_sat(ofy[23], eq_y, eovf_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_load)
            m_valid_reg <= pre_valid;
    end

    // hold the result while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (out_load && pre_valid)
        begin
            frame_x_reg   <= ofx;
            frame_y_reg   <= ofy;
            inside_reg    <= oin;
            clamped_x_reg <= ocx_next;
            clamped_y_reg <= ocy_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = inside_reg;
    assign m_axis_tdata  = {4'd0, clamped_y_reg, clamped_x_reg, frame_y_reg, frame_x_reg};

endmodule

// ----- hw/rtl/w2f_check.sv -----
// Port-level checker for the world to frame transform, bound to the top level.
// Depends on w2f_pkg for the config port widths.
module w2f_check
    import w2f_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [63:0]            s_axis_tdata,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [87:0]            m_axis_tdata,
    input logic                   m_axis_tuser,
    input logic                   cfg_wr_en,
    input logic [CFG_INDEX_W-1:0] cfg_index,
    input logic [CFG_DATA_W-1:0]  cfg_data
);

    logic signed [23:0] fx;
    logic signed [17:0] cx;
    logic signed [17:0] cy;

    assign fx = m_axis_tdata[23:0];
    assign cx = m_axis_tdata[65:48];
    assign cy = m_axis_tdata[83:66];

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // the x coordinate of a point inside the frame is passed through unclamped
    a_inside: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> 24'(cx) == fx)
        else $error("inside point differs from clamped point");

    // clamped point stays on or within the unit frame
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> cx >= -18'sd65536 && cx <= 18'sd65536
                          && cy >= -18'sd65536 && cy <= 18'sd65536)
        else $error("clamped point out of range");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge clk) $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result valid out of reset");

endmodule

bind world_to_frame_transform_core w2f_check u_w2f_check (.*);
